@@ sv/cbr_pkg.sv @@
package cbr_pkg;

  // Default depth of the name / configuration data buffer.
  localparam int unsigned DefStoreDepth = 256;

  // Command-code register file.
  localparam int unsigned NumCodes = 6;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CfgIdxW  = 3;

  // Register indexes, in the order of the register list.
  localparam logic [CfgIdxW-1:0] RegAck        = 3'd0;
  localparam logic [CfgIdxW-1:0] RegListAll    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegListLog    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSendFile   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSendConfig = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNewConfig  = 3'd5;

  // Reset values of the command codes, entry i belongs to register i.
  localparam logic [NumCodes-1:0][CodeW-1:0] CodeReset =
    {8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

  // Field widths.
  localparam int unsigned PhaseW = 4;
  localparam int unsigned WIdxW  = 8;
  localparam int unsigned LenW   = 32;

  // Phase codes seen on the result port.
  localparam logic [PhaseW-1:0] PhaseReady = 4'd0;
  localparam logic [PhaseW-1:0] PhaseError = 4'd13;

  // Result tdata layout, lowest bit first.
  localparam int unsigned OutStateLo = 0;
  localparam int unsigned OutAckBit  = 4;
  localparam int unsigned OutWrBit   = 5;
  localparam int unsigned OutWIdxLo  = 6;
  localparam int unsigned OutLeftLo  = 14;
  localparam int unsigned OutErrBit  = 46;
  localparam int unsigned OutDataW   = 48;

endpackage

@@ sv/command_byte_receiver.sv @@
// Command byte receiver: parses a serial command link one byte per request.
// The result of an accepted request is registered in the result register and shown on m_axis.
// Throughput: one request per cycle; the single result register is refilled in
//   the cycle it is drained, so s_axis_tready only drops while a result is stalled.
// Reset (rst_ni low, asynchronous): phase ready, fill count and length cleared,
//   command codes back to 0..5, no result pending.
module command_byte_receiver #(
  parameter int unsigned STORE_DEPTH = cbr_pkg::DefStoreDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command-code register writes
  input  logic                              cfg_we_i,
  input  logic [cbr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [cbr_pkg::CodeW-1:0]         cfg_data_i,
  // Incoming requests
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [7:0] data_byte
  input  logic                              s_axis_tuser_i,  // [0] func (1 = service tick)
  // Results
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [3:0] parse_state, [4] send_ack, [5] buffer_write, [13:6] write_index,
  // [45:14] bytes_left, [46] error, [47] zero
  output logic [cbr_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  // Fill count runs up to STORE_DEPTH itself so a full name buffer is visible.
  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(STORE_DEPTH);
  localparam logic [CntW-1:0] LastC  = CntW'(STORE_DEPTH - 1);

  typedef enum logic [cbr_pkg::PhaseW-1:0] {
    PH_READY     = 4'd0,
    PH_ACK       = 4'd1,
    PH_LIST_ALL  = 4'd2,
    PH_LIST_LOG  = 4'd3,
    PH_NAME      = 4'd4,
    PH_NAME_DONE = 4'd5,
    PH_SEND_CFG  = 4'd6,
    PH_LEN0      = 4'd7,
    PH_LEN1      = 4'd8,
    PH_LEN2      = 4'd9,
    PH_LEN3      = 4'd10,
    PH_DATA      = 4'd11,
    PH_DATA_DONE = 4'd12,
    PH_ERROR     = 4'd13
  } phase_e;

  // Command-code registers.
  logic [cbr_pkg::NumCodes-1:0][cbr_pkg::CodeW-1:0] codes_q;

  // Parser state.
  phase_e                      phase_q, phase_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [cbr_pkg::LenW-1:0]    rem_q, rem_d;

  // Result register.
  logic                           out_valid_q;
  logic [cbr_pkg::OutDataW-1:0]   out_data_q, out_data_d;

  logic        in_acc;
  logic        ack;
  logic        wrote;
  logic [CntW-1:0] pos;
  logic [31:0] pos_ext;
  logic [cbr_pkg::WIdxW-1:0] widx;
  logic [cbr_pkg::LenW-1:0]  rem_dec;
  logic [cbr_pkg::NumCodes-1:0] hit;
  phase_e      cmd_phase;

  // Accept a request whenever the result register is empty or being drained.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Compare the byte against all six codes at once; lowest register wins.
  always_comb begin
    for (int i = 0; i < cbr_pkg::NumCodes; i++) begin
      hit[i] = (codes_q[i] == s_axis_tdata_i);
    end
    if (hit[cbr_pkg::RegAck]) begin
      cmd_phase = PH_ACK;
    end else if (hit[cbr_pkg::RegListAll]) begin
      cmd_phase = PH_LIST_ALL;
    end else if (hit[cbr_pkg::RegListLog]) begin
      cmd_phase = PH_LIST_LOG;
    end else if (hit[cbr_pkg::RegSendFile]) begin
      cmd_phase = PH_NAME;
    end else if (hit[cbr_pkg::RegSendConfig]) begin
      cmd_phase = PH_SEND_CFG;
    end else if (hit[cbr_pkg::RegNewConfig]) begin
      cmd_phase = PH_LEN0;
    end else begin
      cmd_phase = PH_ERROR;
    end
  end

  // Data bytes wrap: a count at full depth restarts at position zero.
  assign pos     = (fill_q >= DepthC) ? '0 : fill_q;
  assign rem_dec = (rem_q != '0) ? rem_q - 32'd1 : rem_q;

  // Next state and result for the request at the input.
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    rem_d   = rem_q;
    ack     = 1'b0;
    wrote   = 1'b0;
    pos_ext = '0;

    if (s_axis_tuser_i) begin
      // Service tick: only the ack request reacts.
      if (phase_q == PH_ACK) begin
        ack     = 1'b1;
        phase_d = PH_READY;
      end
    end else begin
      case (phase_q)
        PH_READY: begin
          fill_d  = '0;
          rem_d   = '0;
          phase_d = cmd_phase;
        end
        PH_NAME: begin
          if (fill_q >= DepthC) begin
            phase_d = PH_ERROR;
          end else begin
            wrote   = 1'b1;
            pos_ext = 32'(fill_q);
            fill_d  = fill_q + CntW'(1);
            if (s_axis_tdata_i == 8'd0) begin
              phase_d = PH_NAME_DONE;
            end
          end
        end
        PH_LEN0: begin
          rem_d   = {24'd0, s_axis_tdata_i};
          phase_d = PH_LEN1;
        end
        PH_LEN1: begin
          rem_d   = {rem_q[31:16], s_axis_tdata_i, rem_q[7:0]};
          phase_d = PH_LEN2;
        end
        PH_LEN2: begin
          rem_d   = {rem_q[31:24], s_axis_tdata_i, rem_q[15:0]};
          phase_d = PH_LEN3;
        end
        PH_LEN3: begin
          rem_d   = {s_axis_tdata_i, rem_q[23:0]};
          phase_d = ((s_axis_tdata_i == 8'd0) && (rem_q[23:0] == 24'd0)) ?
                    PH_DATA_DONE : PH_DATA;
        end
        PH_DATA: begin
          wrote   = 1'b1;
          pos_ext = 32'(pos);
          fill_d  = (pos == LastC) ? '0 : pos + CntW'(1);
          rem_d   = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_DATA_DONE;
          end
        end
        // Pending, complete and error phases: any byte is an error.
        default: begin
          phase_d = PH_ERROR;
        end
      endcase
    end
  end

  assign widx = pos_ext[cbr_pkg::WIdxW-1:0];

  // Pack the result word; the concatenation lists the highest field first.
  assign out_data_d = {1'b0, (phase_d == PH_ERROR), rem_d, widx, wrote, ack, phase_d};

  // Command-code writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= cbr_pkg::CodeReset;
    end else if (cfg_we_i && (cfg_idx_i < cbr_pkg::CfgIdxW'(cbr_pkg::NumCodes))) begin
      codes_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Parser state advances only on an accepted request; the result register
  // loads on accept and holds while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_READY;
      fill_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (s_axis_tready_o) begin
        out_valid_q <= s_axis_tvalid_i;
      end
      if (in_acc) begin
        phase_q    <= phase_d;
        fill_q     <= fill_d;
        rem_q      <= rem_d;
        out_data_q <= out_data_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ sv/cbr_checker.sv @@
module cbr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [cbr_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  logic [cbr_pkg::PhaseW-1:0] st;
  logic                       err;
  logic                       err_seen_q;

  assign st  = m_axis_tdata_o[cbr_pkg::OutStateLo +: cbr_pkg::PhaseW];
  assign err = m_axis_tdata_o[cbr_pkg::OutErrBit];

  // Remember that an error result went out; error never clears without reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i && err) begin
      err_seen_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (err == (st == cbr_pkg::PhaseError)))
    else $error("error flag disagrees with parse state");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && err_seen_q |-> err)
    else $error("error state left without reset");

  a_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[cbr_pkg::OutAckBit]
      |-> (st == cbr_pkg::PhaseReady) && !m_axis_tdata_o[cbr_pkg::OutWrBit])
    else $error("acknowledge without return to ready");

  a_widx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[cbr_pkg::OutWrBit]
      |-> (m_axis_tdata_o[cbr_pkg::OutWIdxLo +: cbr_pkg::WIdxW] == '0))
    else $error("write index set without a buffer write");

endmodule

bind command_byte_receiver cbr_checker u_cbr_checker (.*);
